// ----- hw/rtl/mas_pkg.sv -----
`default_nettype none
package mas_pkg;

    localparam int MOTOR_BITS = 11;
    localparam int MOTOR_W    = 11;
    localparam int THR_W      = 11;
    localparam int CODE_W     = 3;
    localparam int COUNT_W    = 16;
    localparam int LEVEL_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CMP_W      = ((MOTOR_BITS > LEVEL_W + 1) ? MOTOR_BITS : LEVEL_W + 1) + 1;

    localparam logic [COUNT_W-1:0] ARM_DELAY_RST  = 16'd600;
    localparam logic [LEVEL_W-1:0] RAMP_BASE_RST  = 10'd48;
    localparam logic [LEVEL_W-1:0] RAMP_SPAN_RST  = 10'd250;
    localparam logic [THR_W-1:0]   ARM_THR_RST    = 11'd50;
    localparam logic [THR_W-1:0]   TAKEOFF_THR_RST = 11'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARM_DELAY   = 3'd0,
        CFG_RAMP_BASE   = 3'd1,
        CFG_RAMP_SPAN   = 3'd2,
        CFG_ARM_THR     = 3'd3,
        CFG_TAKEOFF_THR = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        MODE_DISARMED = 5'b00001,
        MODE_ARMING   = 5'b00010,
        MODE_RAMP     = 5'b00100,
        MODE_FLY      = 5'b01000,
        MODE_FAILSAFE = 5'b10000
    } t_mode;

    localparam logic [CODE_W-1:0] CODE_DISARMED = 3'd0;
    localparam logic [CODE_W-1:0] CODE_ARMING   = 3'd1;
    localparam logic [CODE_W-1:0] CODE_RAMP     = 3'd2;
    localparam logic [CODE_W-1:0] CODE_FLY      = 3'd3;
    localparam logic [CODE_W-1:0] CODE_FAILSAFE = 3'd4;

    typedef struct packed {
        logic [COUNT_W-1:0] arm_delay_ticks;
        logic [LEVEL_W-1:0] ramp_base;
        logic [LEVEL_W-1:0] ramp_span;
        logic [THR_W-1:0]   arm_throttle_limit;
        logic [THR_W-1:0]   takeoff_throttle;
    } t_cfg;

    typedef struct packed {
        logic               stop_req;
        logic               link_ok;
        logic [THR_W-1:0]   stick_throttle;
        logic [MOTOR_W-1:0] ctrl_cmd_0;
        logic [MOTOR_W-1:0] ctrl_cmd_1;
        logic [MOTOR_W-1:0] ctrl_cmd_2;
        logic [MOTOR_W-1:0] ctrl_cmd_3;
    } t_tick;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor_a;
        logic [MOTOR_W-1:0] motor_b;
        logic [MOTOR_W-1:0] motor_c;
        logic [MOTOR_W-1:0] motor_d;
        logic [CODE_W-1:0]  mode_code;
        logic               airborne;
        logic               controller_reset;
        logic               controller_run;
    } t_result;

    function automatic logic [CODE_W-1:0] mode_to_code(input t_mode m);
        logic [CODE_W-1:0] c;
        c = CODE_DISARMED;
        unique case (m)
            MODE_DISARMED: c = CODE_DISARMED;
            MODE_ARMING:   c = CODE_ARMING;
            MODE_RAMP:     c = CODE_RAMP;
            MODE_FLY:      c = CODE_FLY;
            MODE_FAILSAFE: c = CODE_FAILSAFE;
            default:       c = CODE_DISARMED;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mas_tick_if.sv -----
`default_nettype none
interface mas_tick_if;
    logic           valid;
    logic           ready;
    mas_pkg::t_tick data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/mas_result_if.sv -----
`default_nettype none
interface mas_result_if;
    logic             valid;
    logic             ready;
    mas_pkg::t_result data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/motor_arming_supervisor_top.sv -----
`default_nettype none
// Motor arming supervisor. Each word on i_tick is one control tick and yields exactly
// one word on o_res in the same order. A tick is processed in the cycle it is accepted:
// the mode, arming counter, ramp level and airborne flag update at that edge and the
// result goes into a two-entry output buffer, so one tick per cycle is sustained as long
// as o_res is drained, and o_res.valid is high in the cycle after acceptance. i_tick
// is stalled only while both buffer entries hold untaken results. stop_req high or
// link_ok low forces failsafe in that same tick. Write the configuration registers
// (0 arm delay, 1 ramp base, 2 ramp span, 3 arm throttle limit, 4 takeoff throttle)
// only while no tick is in flight; writes to other indexes are ignored.
module motor_arming_supervisor_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    mas_tick_if.sink                         i_tick,
    mas_result_if.source                     o_res,
    input  wire                              i_cfg_we,
    input  wire [mas_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [mas_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    mas_pkg::t_cfg    r_cfg;
    mas_pkg::t_result core_res;
    mas_pkg::t_result r_buf [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;
    logic             push;
    logic             pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arm_delay_ticks    <= mas_pkg::ARM_DELAY_RST;
            r_cfg.ramp_base          <= mas_pkg::RAMP_BASE_RST;
            r_cfg.ramp_span          <= mas_pkg::RAMP_SPAN_RST;
            r_cfg.arm_throttle_limit <= mas_pkg::ARM_THR_RST;
            r_cfg.takeoff_throttle   <= mas_pkg::TAKEOFF_THR_RST;
        end else if (i_cfg_we) begin
            unique case (mas_pkg::t_cfg_idx'(i_cfg_idx))
                mas_pkg::CFG_ARM_DELAY:
                    r_cfg.arm_delay_ticks <= i_cfg_data;
                mas_pkg::CFG_RAMP_BASE:
                    r_cfg.ramp_base <= i_cfg_data[mas_pkg::LEVEL_W-1:0];
                mas_pkg::CFG_RAMP_SPAN:
                    r_cfg.ramp_span <= i_cfg_data[mas_pkg::LEVEL_W-1:0];
                mas_pkg::CFG_ARM_THR:
                    r_cfg.arm_throttle_limit <= i_cfg_data[mas_pkg::THR_W-1:0];
                mas_pkg::CFG_TAKEOFF_THR:
                    r_cfg.takeoff_throttle <= i_cfg_data[mas_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_tick.ready = (r_cnt != 2'd2);
    assign push         = i_tick.valid && i_tick.ready;
    assign pop          = o_res.valid && o_res.ready;

    mas_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (push),
        .i_in    (i_tick.data),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wptr] <= core_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_res.valid = (r_cnt != 2'd0);
    assign o_res.data  = r_buf[r_rptr];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer overfilled");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wptr == r_rptr)
        else $error("buffer pointers disagree with fill count");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_res.valid)
        else $error("accepted word not presented on output");

endmodule
`default_nettype wire

// ----- hw/rtl/mas_core.sv -----
`default_nettype none
module mas_core (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_acc,
    input  wire mas_pkg::t_tick     i_in,
    input  wire mas_pkg::t_cfg      i_cfg,
    output mas_pkg::t_result        o_res
);

    mas_pkg::t_mode                  r_mode, n_mode, eff_mode;
    logic [mas_pkg::COUNT_W-1:0]     r_arm_count, n_arm_count;
    logic [mas_pkg::MOTOR_BITS-1:0]  r_ramp_level, n_ramp_level;
    logic                            r_ramp_falling, n_ramp_falling;
    logic                            r_engaged, n_engaged;

    logic                            release_ok;
    logic                            ramp_drive;
    logic                            fly_drive;
    logic                            ctl_rst;

    always_comb begin
        eff_mode = (i_in.stop_req || !i_in.link_ok) ? mas_pkg::MODE_FAILSAFE : r_mode;
        release_ok = !i_in.stop_req && i_in.link_ok &&
                     (i_in.stick_throttle < i_cfg.arm_throttle_limit);

        n_mode         = eff_mode;
        n_arm_count    = r_arm_count;
        n_ramp_level   = r_ramp_level;
        n_ramp_falling = r_ramp_falling;
        n_engaged      = r_engaged;
        ramp_drive     = 1'b0;
        fly_drive      = 1'b0;
        ctl_rst        = 1'b0;

        unique case (eff_mode)
            mas_pkg::MODE_DISARMED: begin
                n_engaged = 1'b0;
                if (release_ok) begin
                    n_arm_count = '0;
                    n_mode      = mas_pkg::MODE_ARMING;
                end
            end
            mas_pkg::MODE_ARMING: begin
                n_engaged   = 1'b0;
                n_arm_count = r_arm_count + 1'b1;
                if (n_arm_count >= i_cfg.arm_delay_ticks) begin
                    n_ramp_level   = mas_pkg::MOTOR_BITS'(i_cfg.ramp_base);
                    n_ramp_falling = 1'b0;
                    n_mode         = mas_pkg::MODE_RAMP;
                end
            end
            mas_pkg::MODE_RAMP: begin
                n_engaged  = 1'b0;
                ramp_drive = 1'b1;
                if (!r_ramp_falling) begin
                    n_ramp_level = r_ramp_level + 1'b1;
                    // turn down once the top of the ramp is reached
                    if (mas_pkg::CMP_W'(n_ramp_level) >=
                        mas_pkg::CMP_W'(i_cfg.ramp_base) + mas_pkg::CMP_W'(i_cfg.ramp_span)) begin
                        n_ramp_falling = 1'b1;
                    end
                end else if (mas_pkg::CMP_W'(r_ramp_level) > mas_pkg::CMP_W'(i_cfg.ramp_base)) begin
                    n_ramp_level = r_ramp_level - 1'b1;
                end else begin
                    n_ramp_level = '0;
                    ctl_rst      = 1'b1;
                    n_mode       = mas_pkg::MODE_FLY;
                end
            end
            mas_pkg::MODE_FLY: begin
                if (!r_engaged && (i_in.stick_throttle < i_cfg.takeoff_throttle)) begin
                    ctl_rst = 1'b1;
                end else begin
                    n_engaged = 1'b1;
                    fly_drive = 1'b1;
                end
            end
            mas_pkg::MODE_FAILSAFE: begin
                n_engaged = 1'b0;
                if (release_ok) begin
                    n_mode  = mas_pkg::MODE_DISARMED;
                    ctl_rst = 1'b1;
                end
            end
            default: begin
                n_mode = mas_pkg::MODE_DISARMED;
            end
        endcase
    end

    always_comb begin
        o_res = '0;
        if (ramp_drive) begin
            o_res.motor_a = mas_pkg::MOTOR_W'(n_ramp_level);
            o_res.motor_b = mas_pkg::MOTOR_W'(n_ramp_level);
            o_res.motor_c = mas_pkg::MOTOR_W'(n_ramp_level);
            o_res.motor_d = mas_pkg::MOTOR_W'(n_ramp_level);
        end else if (fly_drive) begin
            // swap slots pairwise: 1, 0, 3, 2
            o_res.motor_a = i_in.ctrl_cmd_1;
            o_res.motor_b = i_in.ctrl_cmd_0;
            o_res.motor_c = i_in.ctrl_cmd_3;
            o_res.motor_d = i_in.ctrl_cmd_2;
        end
        o_res.mode_code        = mas_pkg::mode_to_code(n_mode);
        o_res.airborne         = n_engaged;
        o_res.controller_reset = ctl_rst;
        o_res.controller_run   = fly_drive;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= mas_pkg::MODE_DISARMED;
            r_arm_count    <= '0;
            r_ramp_level   <= '0;
            r_ramp_falling <= 1'b0;
            r_engaged      <= 1'b0;
        end else if (i_acc) begin
            r_mode         <= n_mode;
            r_arm_count    <= n_arm_count;
            r_ramp_level   <= n_ramp_level;
            r_ramp_falling <= n_ramp_falling;
            r_engaged      <= n_engaged;
        end
    end

    a_kill_holds_failsafe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && i_in.stop_req |=> r_mode == mas_pkg::MODE_FAILSAFE)
        else $error("stop request did not leave the block in failsafe");

    a_run_needs_engaged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && o_res.controller_run |=> r_engaged && r_mode == mas_pkg::MODE_FLY)
        else $error("controller ran without being engaged in fly");

    a_arm_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && r_mode == mas_pkg::MODE_ARMING && !i_in.stop_req && i_in.link_ok
        |=> r_arm_count == mas_pkg::COUNT_W'($past(r_arm_count) + 1'b1))
        else $error("arming counter did not advance by one");

    a_reset_motors_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && o_res.controller_reset |-> !o_res.controller_run && o_res.motor_a == '0)
        else $error("motors driven in a controller reset tick");

endmodule
`default_nettype wire
